// ===== hdl/oers_pkg.sv =====
// ---------------------------------------------------------------------------
// OSD element refresh scheduler package
// Shared word types, command codes and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package oers_pkg;

	// Default table sizes
	localparam int MAX_ELEMS_DEF = 32;
	localparam int TEXT_LEN_DEF  = 16;

	// Fixed field widths
	localparam int ELEM_W  = 5;
	localparam int POS_W   = 7;
	localparam int SLOT_W  = 4;
	localparam int CHAR_W  = 8;
	localparam int DADDR_W = 9;

	// Command queue depth between front and back
	localparam int QUEUE_DEPTH = 4;

	// Reset value of the screen width register
	localparam logic [POS_W-1:0] SCREEN_WIDTH_RST = 7'd30;

	// Input kind codes
	localparam logic [2:0] KIND_PLACE = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_SHOW  = 3'd2;
	localparam logic [2:0] KIND_HIDE  = 3'd3;
	localparam logic [2:0] KIND_TICK  = 3'd4;

	// Input word
	typedef struct packed {
		logic [2:0]        kind;
		logic [ELEM_W-1:0] elem_index;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [SLOT_W-1:0] char_slot;
		logic [CHAR_W-1:0] char_code;
		logic              text_end;
	} in_word_t;

	// Output word
	typedef struct packed {
		logic [DADDR_W-1:0] display_address;
		logic [CHAR_W-1:0]  display_char;
		logic               run_last;
	} out_word_t;

	// Classified command
	typedef enum logic [2:0] {
		OP_PLACE,
		OP_WRITE,
		OP_SHOW,
		OP_HIDE,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ELEM_W-1:0] elem;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [SLOT_W-1:0] slot;
		logic [CHAR_W-1:0] code;
		logic              tend;
	} cmd_t;

	// Push request from the front into the queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_push_t;

endpackage

`default_nettype wire

// ===== hdl/oers_front.sv =====
// ---------------------------------------------------------------------------
// OSD scheduler front end
// Accepts input words, drops those that do nothing and turns the rest into
// commands for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module oers_front #(
	parameter int MAX_ELEMS = oers_pkg::MAX_ELEMS_DEF,
	parameter int TEXT_LEN  = oers_pkg::TEXT_LEN_DEF
) (
	input  wire                 in_valid,
	output logic                in_stall,
	input  oers_pkg::in_word_t  in_word,
	input  wire                 q_full,
	input  wire                 clear_busy,
	output oers_pkg::q_push_t   push
);
	import oers_pkg::*;

	logic elem_ok;
	logic slot_ok;
	logic useful;
	op_t  op;

	// Hold the input off while the queue is full or the text store is clearing.
	assign in_stall = q_full || clear_busy;

	assign elem_ok = int'(in_word.elem_index) < MAX_ELEMS;
	assign slot_ok = int'(in_word.char_slot) < TEXT_LEN;

	// Classify the word by its kind.
	always_comb begin
		op     = OP_TICK;
		useful = 1'b0;
		case (in_word.kind)
			KIND_PLACE: begin
				op     = OP_PLACE;
				useful = elem_ok;
			end
			KIND_WRITE: begin
				op     = OP_WRITE;
				useful = elem_ok && slot_ok;
			end
			KIND_SHOW: begin
				op     = OP_SHOW;
				useful = elem_ok;
			end
			KIND_HIDE: begin
				op     = OP_HIDE;
				useful = elem_ok;
			end
			KIND_TICK: begin
				op     = OP_TICK;
				useful = 1'b1;
			end
			default: begin
				op     = OP_TICK;
				useful = 1'b0;
			end
		endcase
	end

	// Build the queue entry.
	always_comb begin
		push.valid    = in_valid && !in_stall && useful;
		push.cmd.op   = op;
		push.cmd.elem = in_word.elem_index;
		push.cmd.col  = in_word.col;
		push.cmd.row  = in_word.row;
		push.cmd.slot = in_word.char_slot;
		push.cmd.code = in_word.char_code;
		push.cmd.tend = in_word.text_end;
	end

endmodule

`default_nettype wire

// ===== hdl/oers_queue.sv =====
// ---------------------------------------------------------------------------
// OSD scheduler command queue
// Short first-in first-out buffer that decouples the front from the back.
// ---------------------------------------------------------------------------
`default_nettype none

module oers_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  oers_pkg::q_push_t  push,
	output logic               q_full,
	output logic               pop_valid,
	input  wire                pop_ready,
	output oers_pkg::cmd_t     pop_cmd
);
	import oers_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign q_full    = count_q == QCW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push.valid && !q_full;
	assign do_pop    = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/oers_back.sv =====
// ---------------------------------------------------------------------------
// OSD scheduler back end
// Executes queued commands on the element table and text store, runs the
// round-robin search on a tick and streams the redraw writes.
// ---------------------------------------------------------------------------
`default_nettype none

module oers_back #(
	parameter int MAX_ELEMS = oers_pkg::MAX_ELEMS_DEF,
	parameter int TEXT_LEN  = oers_pkg::TEXT_LEN_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [oers_pkg::POS_W-1:0]       cfg_wdata,
	input  wire                              pop_valid,
	output logic                             pop_ready,
	input  oers_pkg::cmd_t                   pop_cmd,
	output logic                             clear_busy,
	output logic                             out_valid,
	input  wire                              out_stall,
	output oers_pkg::out_word_t              out_word
);
	import oers_pkg::*;

	localparam int EW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int TXT_DEPTH = MAX_ELEMS * TEXT_LEN;
	localparam int TAW       = (TXT_DEPTH > 1) ? $clog2(TXT_DEPTH) : 1;
	localparam int IW        = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
	localparam int PW        = 2 * POS_W;
	localparam int BW        = 2 * POS_W + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_BASE,
		ST_LOOK,
		ST_LAST
	} state_t;

	state_t              state_q;
	logic [TAW-1:0]      clr_q;
	logic [MAX_ELEMS-1:0] upd_q;
	logic [MAX_ELEMS-1:0] vis_q;
	logic [MAX_ELEMS-1:0] pos_vld_q;
	logic [EW-1:0]       last_q;
	logic [EW-1:0]       cur_q;
	logic [IW-1:0]       idx_q;
	logic [DADDR_W-1:0]  addr_q;
	logic [CHAR_W-1:0]   pend_q;
	logic [POS_W-1:0]    width_q;
	logic                out_valid_q;
	out_word_t           out_word_q;

	// Memories
	logic [CHAR_W-1:0]   txt_mem [TXT_DEPTH];
	logic [CHAR_W-1:0]   txt_rd_q;
	logic [PW-1:0]       pos_mem [MAX_ELEMS];
	logic [PW-1:0]       pos_rd_q;

	logic                txt_we;
	logic [TAW-1:0]      txt_waddr;
	logic [CHAR_W-1:0]   txt_wdata;
	logic                txt_re;
	logic [TAW-1:0]      txt_raddr;
	logic                pos_we;
	logic                pos_re;

	logic [EW-1:0]       cmd_elem;
	logic                do_pop;
	logic                hit;
	logic                out_free;
	logic                emit;
	out_word_t           emit_word;
	logic [POS_W-1:0]    pos_col;
	logic [POS_W-1:0]    pos_row;
	logic [BW-1:0]       base_sum;
	logic                char_zero;
	logic                idx_end;

	// Text store address of a slot within an element.
	function automatic logic [TAW-1:0] taddr(input logic [EW-1:0] e,
			input logic [SLOT_W-1:0] s);
		logic [TAW-1:0] row_base;
		row_base = TAW'(int'(e) * TEXT_LEN);
		return row_base + TAW'(s);
	endfunction

	// Round-robin successor of an element index.
	function automatic logic [EW-1:0] next_elem(input logic [EW-1:0] e);
		logic [EW-1:0] n;
		if (e == EW'(MAX_ELEMS - 1)) begin
			n = '0;
		end else begin
			n = e + 1'b1;
		end
		return n;
	endfunction

	assign cmd_elem   = EW'(pop_cmd.elem);
	assign pop_ready  = state_q == ST_IDLE;
	assign do_pop     = pop_valid && pop_ready;
	assign clear_busy = state_q == ST_CLEAR;
	assign hit        = upd_q[cur_q] && vis_q[cur_q];
	assign out_free   = !out_valid_q || !out_stall;
	assign char_zero  = txt_rd_q == '0;
	assign idx_end    = idx_q == IW'(TEXT_LEN - 1);
	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;

	// Start position of a redraw: col + row * width, kept to nine bits.
	assign pos_col  = pos_vld_q[cur_q] ? pos_rd_q[POS_W-1:0] : '0;
	assign pos_row  = pos_vld_q[cur_q] ? pos_rd_q[PW-1:POS_W] : '0;
	assign base_sum = BW'(pos_col) + BW'(BW'(pos_row) * BW'(width_q));

	// Next display word.
	always_comb begin
		emit = ((state_q == ST_LOOK) || (state_q == ST_LAST)) && out_free;
		emit_word.display_address = addr_q;
		emit_word.display_char    = pend_q;
		emit_word.run_last        = (state_q == ST_LAST) || char_zero;
	end

	// Memory port selection.
	always_comb begin
		txt_we    = 1'b0;
		txt_waddr = taddr(cmd_elem, pop_cmd.slot);
		txt_wdata = pop_cmd.code;
		txt_re    = 1'b0;
		txt_raddr = taddr(cur_q, '0);
		pos_we    = 1'b0;
		pos_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				txt_we    = 1'b1;
				txt_waddr = clr_q;
				txt_wdata = '0;
			end
			ST_IDLE: begin
				txt_we = do_pop && (pop_cmd.op == OP_WRITE);
				pos_we = do_pop && (pop_cmd.op == OP_PLACE);
			end
			ST_SCAN: begin
				txt_re = hit;
				pos_re = hit;
			end
			ST_BASE: begin
				txt_re    = (TEXT_LEN > 1) && !char_zero;
				txt_raddr = taddr(cur_q, SLOT_W'(1));
			end
			ST_LOOK: begin
				txt_re    = out_free && !char_zero && !idx_end;
				txt_raddr = taddr(cur_q, SLOT_W'(idx_q) + SLOT_W'(1));
			end
			default: begin
				txt_re = 1'b0;
			end
		endcase
	end

	// Text store, cleared after reset.
	always_ff @(posedge clk) begin
		if (txt_we) begin
			txt_mem[txt_waddr] <= txt_wdata;
		end
		if (txt_re) begin
			txt_rd_q <= txt_mem[txt_raddr];
		end
	end

	// Element position store; entries never placed read as zero.
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[cmd_elem] <= {pop_cmd.row, pop_cmd.col};
		end
		if (pos_re) begin
			pos_rd_q <= pos_mem[cur_q];
		end
	end

	// Sequencer, flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			upd_q       <= '0;
			vis_q       <= '0;
			pos_vld_q   <= '0;
			last_q      <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			addr_q      <= '0;
			pend_q      <= '0;
			width_q     <= SCREEN_WIDTH_RST;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_word_q  <= emit_word;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TAW'(TXT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (do_pop) begin
						case (pop_cmd.op)
							OP_PLACE: pos_vld_q[cmd_elem] <= 1'b1;
							OP_WRITE: begin
								if (pop_cmd.tend) begin
									upd_q[cmd_elem] <= 1'b1;
								end
							end
							OP_SHOW: vis_q[cmd_elem] <= 1'b1;
							OP_HIDE: vis_q[cmd_elem] <= 1'b0;
							OP_TICK: begin
								cur_q   <= next_elem(last_q);
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					// One element per cycle; the last one served is checked last.
					if (hit) begin
						upd_q[cur_q] <= 1'b0;
						last_q       <= cur_q;
						state_q      <= ST_BASE;
					end else if (cur_q == last_q) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q <= next_elem(cur_q);
					end
				end
				ST_BASE: begin
					addr_q <= base_sum[DADDR_W-1:0];
					pend_q <= txt_rd_q;
					if (char_zero) begin
						state_q <= ST_IDLE;
					end else if (TEXT_LEN == 1) begin
						state_q <= ST_LAST;
					end else begin
						idx_q   <= IW'(1);
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// Character idx_q is in hand; it decides whether the pending one ends the run.
					if (out_free) begin
						if (char_zero) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q <= addr_q + 1'b1;
							pend_q <= txt_rd_q;
							if (idx_end) begin
								state_q <= ST_LAST;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/osd_element_refresh_scheduler_core.sv =====
// Place, write, show and hide are queued and take effect when the idle back pops them.
// A tick goes through the queue, a search of up to MAX_ELEMS elements (one element per cycle),
// the start position and then the character writes in slot order, held while the output
// stalls. Throughput: one non-tick word per cycle unless the input is stalled; a tick
// holds the back until its redraw is out.
// Reset: asynchronous; the text store is then cleared entry by entry with the input stalled.
// ---------------------------------------------------------------------------
// OSD element refresh scheduler
// Keeps a table of on-screen text elements and, on each tick, redraws the
// next updated and visible element as a run of display memory writes.
// ---------------------------------------------------------------------------
`default_nettype none

module osd_element_refresh_scheduler_core #(
	parameter int MAX_ELEMS = oers_pkg::MAX_ELEMS_DEF,
	parameter int TEXT_LEN  = oers_pkg::TEXT_LEN_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire  [oers_pkg::POS_W-1:0] cfg_wdata,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  oers_pkg::in_word_t         in_word,
	output logic                       out_valid,
	input  wire                        out_stall,
	output oers_pkg::out_word_t        out_word
);
	import oers_pkg::*;

	q_push_t push;
	logic    q_full;
	logic    clear_busy;
	logic    pop_valid;
	logic    pop_ready;
	cmd_t    pop_cmd;

	// Front: accept and classify.
	oers_front #(
		.MAX_ELEMS(MAX_ELEMS),
		.TEXT_LEN (TEXT_LEN)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.q_full    (q_full),
		.clear_busy(clear_busy),
		.push      (push)
	);

	// Command queue.
	oers_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (q_full),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_cmd  (pop_cmd)
	);

	// Back: execute and redraw.
	oers_back #(
		.MAX_ELEMS(MAX_ELEMS),
		.TEXT_LEN (TEXT_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.clear_busy(clear_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// ===== hdl/oers_checker.sv =====
// ---------------------------------------------------------------------------
// OSD scheduler port checker
// Watches the top-level ports for stall, reset and redraw-run rules.
// ---------------------------------------------------------------------------
`default_nettype none

module oers_checker #(
	parameter int TEXT_LEN = oers_pkg::TEXT_LEN_DEF
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input oers_pkg::out_word_t out_word
);
	import oers_pkg::*;

	logic               out_acc;
	logic               in_run_q;
	logic [4:0]         run_cnt_q;
	logic [DADDR_W-1:0] last_addr_q;

	assign out_acc = out_valid && !out_stall;

	// Track position inside the current redraw run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			run_cnt_q   <= '0;
			last_addr_q <= '0;
		end else if (out_acc) begin
			in_run_q    <= !out_word.run_last;
			run_cnt_q   <= out_word.run_last ? 5'd0 : run_cnt_q + 5'd1;
			last_addr_q <= out_word.display_address;
		end
	end

	// A stalled word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// Reset empties the output register by the next edge.
	a_reset_out: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// The store clear keeps the input stalled right after reset.
	a_clear_stall: assert property (@(posedge clk) $rose(arst_n) |-> in_stall)
		else $error("input taken before the text store was cleared");

	// A run never exceeds the text length.
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> int'(run_cnt_q) < TEXT_LEN)
		else $error("redraw run longer than the text length");

	// Addresses step by one within a run.
	a_run_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && in_run_q |-> out_word.display_address == last_addr_q + 9'd1)
		else $error("display address not consecutive within a run");

endmodule

bind osd_element_refresh_scheduler_core oers_checker #(
	.TEXT_LEN(TEXT_LEN)
) u_oers_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

`default_nettype wire

// ===== bench/oers_display_checker.sv =====
// ---------------------------------------------------------------------------
// OSD element refresh scheduler display checker
// Watches the command, configuration and display channels of the scheduler.
// It keeps its own copy of the element table, predicts the display writes
// of every redraw, and compares each accepted write field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module oers_display_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire  [oers_pkg::POS_W-1:0] cfg_wdata,
	input  wire                        in_valid,
	input  wire                        in_stall,
	input  oers_pkg::in_word_t         in_word,
	input  wire                        out_valid,
	input  wire                        out_stall,
	input  oers_pkg::out_word_t        out_word,
	output int                         pending_writes,
	output int                         mismatch_count
);
	import oers_pkg::*;

	localparam int N_ELEMS = MAX_ELEMS_DEF;
	localparam int N_CHARS = TEXT_LEN_DEF;

	// Shadow copy of the element table.
	logic              upd_flag  [N_ELEMS];
	logic              vis_flag  [N_ELEMS];
	logic [POS_W-1:0]  elem_x    [N_ELEMS];
	logic [POS_W-1:0]  elem_y    [N_ELEMS];
	logic [CHAR_W-1:0] text_mem  [N_ELEMS][N_CHARS];
	logic [ELEM_W-1:0] last_served;
	logic [POS_W-1:0]  screen_width;

	// Display writes predicted but not yet seen.
	out_word_t expected_writes[$];
	int        n_mismatch;

	task automatic report_mismatch(input string msg);
		$display("[%0t] display check: %s", $realtime, msg);
		n_mismatch++;
	endtask

	// Queue the display writes of one element redraw.
	task automatic queue_redraw(input logic [ELEM_W-1:0] e);
		logic [31:0] pos;
		out_word_t   w;
		upd_flag[e] = 1'b0;
		pos = 32'(elem_x[e]) + 32'(elem_y[e]) * 32'(screen_width);
		for (int i = 0; i < N_CHARS; i++) begin
			if (text_mem[e][i] == 8'h00)
				break;
			w.display_address = pos[DADDR_W-1:0];
			w.display_char    = text_mem[e][i];
			// The run ends at the last slot or just before a zero byte.
			w.run_last = (i == N_CHARS-1) ? 1'b1 : (text_mem[e][i+1] == 8'h00);
			expected_writes.push_back(w);
			pos = (pos + 32'd1) & 32'h1FF;
		end
	endtask

	// Round-robin search starting after the last element served.
	task automatic serve_tick();
		logic [ELEM_W-1:0] probe;
		bit                found;
		probe = last_served;
		found = 1'b0;
		for (int k = 0; k < N_ELEMS && !found; k++) begin
			probe = (probe == N_ELEMS-1) ? '0 : probe + 1'b1;
			if (upd_flag[probe] && vis_flag[probe])
				found = 1'b1;
			else if (probe == last_served)
				break;
		end
		if (found) begin
			last_served = probe;
			queue_redraw(probe);
		end
	endtask

	task automatic apply_word(input in_word_t w);
		case (w.kind)
			KIND_TICK: begin
				serve_tick();
			end
			KIND_PLACE: begin
				elem_x[w.elem_index] = w.col;
				elem_y[w.elem_index] = w.row;
			end
			KIND_WRITE: begin
				text_mem[w.elem_index][w.char_slot] = w.char_code;
				if (w.text_end)
					upd_flag[w.elem_index] = 1'b1;
			end
			KIND_SHOW: begin
				vis_flag[w.elem_index] = 1'b1;
			end
			KIND_HIDE: begin
				vis_flag[w.elem_index] = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_write(input out_word_t got);
		out_word_t want;
		if (expected_writes.size() == 0) begin
			report_mismatch($sformatf("unexpected write addr %0d char %02h last %0b",
				got.display_address, got.display_char, got.run_last));
		end else begin
			want = expected_writes.pop_front();
			if (got.display_address !== want.display_address)
				report_mismatch($sformatf("display_address got %0d want %0d",
					got.display_address, want.display_address));
			if (got.display_char !== want.display_char)
				report_mismatch($sformatf("display_char got %02h want %02h",
					got.display_char, want.display_char));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last got %0b want %0b at addr %0d",
					got.run_last, want.run_last, want.display_address));
		end
	endtask

	// Follow every accepted word on each channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < N_ELEMS; e++) begin
				upd_flag[e] = 1'b0;
				vis_flag[e] = 1'b0;
				elem_x[e]   = '0;
				elem_y[e]   = '0;
				for (int c = 0; c < N_CHARS; c++)
					text_mem[e][c] = '0;
			end
			last_served  = '0;
			screen_width = SCREEN_WIDTH_RST;
			expected_writes.delete();
			n_mismatch   = 0;
		end else begin
			if (cfg_we)
				screen_width = cfg_wdata;
			if (in_valid && !in_stall)
				apply_word(in_word);
			if (out_valid && !out_stall)
				compare_write(out_word);
		end
		pending_writes <= expected_writes.size();
		mismatch_count <= n_mismatch;
	end

endmodule

`default_nettype wire

// ===== bench/osd_element_refresh_scheduler_core_tb.sv =====
// ---------------------------------------------------------------------------
// OSD element refresh scheduler testbench
// Drives command words and screen width settings into the scheduler, stalls
// the display side at random, and lets the display checker judge every write.
// A directed part covers the corner cases, then random element updates run
// under several screen widths.
// ---------------------------------------------------------------------------
`default_nettype none

module osd_element_refresh_scheduler_core_tb;
	import oers_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int LONG_HOLD      = 300;
	localparam int PHASE_WORDS    = 18;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [POS_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_word_t         in_word   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_word;

	int pending_writes;
	int mismatch_count;
	int words_sent   = 0;
	int idle_cycles  = 0;
	int hold_request = 0;
	bit quick_in     = 1'b0;
	bit quick_out    = 1'b0;

	osd_element_refresh_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	oers_display_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_word       (out_word),
		.pending_writes (pending_writes),
		.mismatch_count (mismatch_count)
	);

	// Clock with a period of 12.
	always begin
		#6;
		clk = 1'b1;
		#6;
		clk = 1'b0;
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// Display side: random stall before each word, one long hold on request.
	initial begin
		int wait_cycles;
		forever begin
			wait_cycles = quick_out ? 0 : $urandom_range(0, 10);
			if (hold_request > 0) begin
				wait_cycles  = hold_request;
				hold_request = 0;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_word_t make_word(input logic [2:0] k, input logic [ELEM_W-1:0] e,
		input logic [POS_W-1:0] c, input logic [POS_W-1:0] r, input logic [SLOT_W-1:0] s,
		input logic [CHAR_W-1:0] ch, input logic te);
		in_word_t w;
		w.kind       = k;
		w.elem_index = e;
		w.col        = c;
		w.row        = r;
		w.char_slot  = s;
		w.char_code  = ch;
		w.text_end   = te;
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.kind       = ($urandom_range(0, 3) == 0) ? KIND_TICK : 3'($urandom_range(0, 7));
		w.elem_index = ELEM_W'($urandom_range(0, 31));
		w.col        = POS_W'($urandom_range(0, 127));
		w.row        = POS_W'($urandom_range(0, 127));
		w.char_slot  = SLOT_W'($urandom_range(0, 15));
		w.char_code  = CHAR_W'($urandom_range(0, 255));
		w.text_end   = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Offer one word after a random gap and hold it until accepted.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = quick_in ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		if (w.kind <= KIND_TICK)
			words_sent++;
	endtask

	// Write a text of len characters, closed by a zero byte most of the time.
	task automatic post_text(input logic [ELEM_W-1:0] e, input int len);
		bit close_it;
		close_it = (len < TEXT_LEN_DEF) && ($urandom_range(0, 2) != 0);
		for (int s = 0; s < len; s++)
			send_word(make_word(KIND_WRITE, e, POS_W'($urandom_range(0, 127)),
				POS_W'($urandom_range(0, 127)), SLOT_W'(s),
				CHAR_W'($urandom_range(1, 255)), (s == len-1) && !close_it));
		if (close_it)
			send_word(make_word(KIND_WRITE, e, POS_W'($urandom_range(0, 127)),
				POS_W'($urandom_range(0, 127)), SLOT_W'(len), 8'h00, 1'b1));
	endtask

	// A well-formed element update: place at random, text, show most of the time, then ticks.
	task automatic run_update();
		logic [ELEM_W-1:0] e;
		int                len;
		int                ticks;
		e     = ELEM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
			: $urandom_range(0, 5));
		len   = ($urandom_range(0, 9) == 0) ? TEXT_LEN_DEF : $urandom_range(0, 4);
		ticks = $urandom_range(1, 2);
		if ($urandom_range(0, 1) == 1)
			send_word(make_word(KIND_PLACE, e, POS_W'($urandom_range(0, 127)),
				POS_W'($urandom_range(0, 127)), SLOT_W'($urandom_range(0, 15)),
				CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		post_text(e, len);
		if ($urandom_range(0, 3) != 0)
			send_word(make_word(KIND_SHOW, e, POS_W'($urandom_range(0, 127)),
				POS_W'($urandom_range(0, 127)), SLOT_W'($urandom_range(0, 15)),
				CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
		repeat (ticks)
			send_word(make_word(KIND_TICK, ELEM_W'($urandom_range(0, 31)),
				POS_W'($urandom_range(0, 127)), POS_W'($urandom_range(0, 127)),
				SLOT_W'($urandom_range(0, 15)), CHAR_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1))));
	endtask

	// Change the screen width once every display write is out and the block is quiet.
	task automatic set_screen_width(input logic [POS_W-1:0] width);
		in_valid <= 1'b0;
		while (pending_writes != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input logic [POS_W-1:0] width, input bit quick, input bit hold);
		int target;
		set_screen_width(width);
		quick_in  = quick;
		quick_out = quick;
		if (hold)
			hold_request = LONG_HOLD;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) begin
			if ($urandom_range(0, 99) < 60)
				run_update();
			else
				send_word(random_word());
		end
		quick_in  = 1'b0;
		quick_out = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Address wraps past 511 from the far corner of the screen.
		send_word(make_word(KIND_PLACE, 5'd0, 7'd127, 7'd127, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_WRITE, 5'd0, 7'd0, 7'd0, 4'd0, 8'hFF, 1'b0));
		send_word(make_word(KIND_WRITE, 5'd0, 7'd127, 7'd127, 4'd1, 8'h01, 1'b1));
		send_word(make_word(KIND_SHOW, 5'd0, 7'd0, 7'd0, 4'd15, 8'hFF, 1'b1));
		send_word(make_word(KIND_TICK, 5'd31, 7'd127, 7'd0, 4'd15, 8'h00, 1'b1));
		// Nothing is ready now.
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd127, 4'd0, 8'hFF, 1'b0));
		// An element with an empty text is served without any write.
		send_word(make_word(KIND_WRITE, 5'd31, 7'd0, 7'd0, 4'd15, 8'h80, 1'b1));
		send_word(make_word(KIND_SHOW, 5'd31, 7'd127, 7'd127, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		// Placing keeps the flags; the search wraps from the top element to zero.
		send_word(make_word(KIND_PLACE, 5'd0, 7'd0, 7'd0, 4'd15, 8'hFF, 1'b1));
		send_word(make_word(KIND_WRITE, 5'd0, 7'd0, 7'd0, 4'd0, 8'h7F, 1'b1));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		// A hidden element waits; a zero byte shortens the text and a later write lengthens it again.
		send_word(make_word(KIND_HIDE, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_WRITE, 5'd0, 7'd0, 7'd0, 4'd1, 8'h00, 1'b1));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_SHOW, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		send_word(make_word(KIND_WRITE, 5'd0, 7'd0, 7'd0, 4'd1, 8'h41, 1'b1));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));
		// Unknown kinds do nothing.
		send_word(make_word(3'd5, 5'd0, 7'd127, 7'd127, 4'd15, 8'hFF, 1'b1));
		send_word(make_word(3'd6, 5'd31, 7'd0, 7'd0, 4'd0, 8'h00, 1'b1));
		send_word(make_word(3'd7, 5'd0, 7'd127, 7'd0, 4'd15, 8'hFF, 1'b1));
		send_word(make_word(KIND_TICK, 5'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0));

		// Random updates under several screen widths.
		run_phase(7'd1, 1'b0, 1'b0);
		run_phase(7'd127, 1'b1, 1'b1);
		run_phase(7'd0, 1'b0, 1'b0);
		run_phase(POS_W'($urandom_range(1, 126)), 1'b0, 1'b0);

		in_valid <= 1'b0;
		while (pending_writes != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_writes == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/oers_pkg.sv
hdl/oers_front.sv
hdl/oers_queue.sv
hdl/oers_back.sv
hdl/osd_element_refresh_scheduler_core.sv
hdl/oers_checker.sv
bench/oers_display_checker.sv
bench/osd_element_refresh_scheduler_core_tb.sv
